### src/cbt_pkg.sv
package cbt_pkg;

  // field and register widths
  localparam int PT_W      = 18;
  localparam int SEG_W     = 6;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = 32;

  // shared multiplier and datapath widths
  localparam int SPAN_W  = 33;
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W;
  localparam int SQ_W    = 12;
  localparam int WT_W    = 20;
  localparam int CUBE_W  = 18;

  // divider widths
  localparam int DIVD_W = 38;
  localparam int DIVS_W = CUBE_W + 1;
  localparam int QUOT_W = PT_W;

  localparam int MAX_SEGMENTS_DEF    = 63;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int BINOM_MID           = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y    = 3'd4;

  // configuration reset values
  localparam logic [SEG_W-1:0]        SEGMENTS_RST = 6'd10;
  localparam logic signed [CFG_W-1:0] MIN_RST      = 32'sd0;
  localparam logic signed [CFG_W-1:0] MAX_RST      = 32'sd65536;

  // output saturation bounds
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh0000_0000_7fff_ffff);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh0000_0000_8000_0000);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SS,
    ST_SSS,
    ST_D,
    ST_AA,
    ST_BB,
    ST_W0,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_ACC,
    ST_DIV,
    ST_DIV_WAIT,
    ST_MAP,
    ST_RND,
    ST_SAT,
    ST_EMIT
  } seq_state_t;

endpackage

### src/cbt_div.sv
module cbt_div
  import cbt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DIVD_W-1:0] dividend,
  input  logic        [DIVS_W-1:0] divisor,
  output logic                     done,
  output logic signed [QUOT_W-1:0] quotient
);

  // floor division, quotient known to fit QUOT_W signed bits,
  // so the remainder starts from the upper dividend bits
  localparam int MAG_W = QUOT_W + DIVS_W;
  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [DIVS_W-1:0] rem;
  logic [QUOT_W-1:0] quo;
  logic [DIVS_W-1:0] dvs;
  logic              neg;

  logic [MAG_W-1:0]  mag;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              fits;
  logic [QUOT_W:0]   qn;

  always_comb begin
    mag   = MAG_W'(dividend[DIVD_W-1] ? -dividend : dividend);
    trial = {rem, quo[QUOT_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
    // negative and inexact rounds one further down
    if (neg) begin
      qn = (rem != '0) ? ~{1'b0, quo} : -{1'b0, quo};
    end else begin
      qn = {1'b0, quo};
    end
    quotient = qn[QUOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(QUOT_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DIVD_W-1];
      dvs <= divisor;
      rem <= mag[MAG_W-1:QUOT_W];
      quo <= mag[QUOT_W-1:0];
    end else if (cnt != '0) begin
      rem <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quo <= {quo[QUOT_W-2:0], fits};
    end
  end

endmodule

### src/cubic_bezier_tessellator.sv
// cubic bezier tessellator: takes one cubic segment per input beat (start point,
// two handles, end point, signed q2.16) and emits `segments` points at
// t = k/segments, k = 0 .. segments-1, followed by the end point when the beat
// is flagged as the curve's closing segment; last_point marks the final point
// of each segment. each point is the exact cubic value rounded to the nearest
// coordinate step (ties up), then remapped per axis as (max-min)*p + min into
// q16.16 and saturated to 32 bits. a segments value of 0 acts as 1, values
// above MAX_SEGMENTS act as MAX_SEGMENTS, and max below min mirrors the range.
// one segment at a time: the block takes a beat only when idle, then works
// through the S points of the effective segment count (plus the closing end
// point), and an output stall holds it longer. each curve point uses the single
// shared 33x21 multiplier (weights, four products per axis, remap) and the
// 18-step restoring divider once per axis; the end point needs only the remap.
// the user writes configuration via cfg_write/cfg_index/cfg_data only while
// idle, not enforced by the block; indexes past the last register are ignored.
module cubic_bezier_tessellator
  import cbt_pkg::*;
#(
  parameter int MAX_SEGMENTS    = MAX_SEGMENTS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,

  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,

  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [PT_W-1:0]   start_x,
  input  logic signed [PT_W-1:0]   start_y,
  input  logic signed [PT_W-1:0]   handle_a_x,
  input  logic signed [PT_W-1:0]   handle_a_y,
  input  logic signed [PT_W-1:0]   handle_b_x,
  input  logic signed [PT_W-1:0]   handle_b_y,
  input  logic signed [PT_W-1:0]   end_x,
  input  logic signed [PT_W-1:0]   end_y,
  input  logic                     closing_segment,

  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [OUT_W-1:0]  point_x,
  output logic signed [OUT_W-1:0]  point_y,
  output logic                     last_point
);

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (COORD_FRAC_BITS - 1);

  // configuration registers
  logic        [SEG_W-1:0] segments;
  logic signed [CFG_W-1:0] min_x, max_x, min_y, max_y;

  // sequencer control
  seq_state_t state, state_next;
  logic [SEG_W-1:0] k;
  logic             axis;     // 0 = x, 1 = y
  logic             endpt;    // emitting the closing end point

  // segment payload
  logic signed [PT_W-1:0]   hx [4];
  logic signed [PT_W-1:0]   hy [4];
  logic                     closing;
  logic [SEG_W-1:0]         s_reg;
  logic signed [SPAN_W-1:0] span_x, span_y;

  // shared multiplier and working registers
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [SQ_W-1:0]           aa, bb;
  logic [WT_W-1:0]           w0, w1, w2, w3;
  logic [CUBE_W-1:0]         d;
  logic signed [ACC_W-1:0]   acc;
  logic signed [PT_W-1:0]    p;
  logic signed [OUT_W-1:0]   res_x, res_y;

  // divider hookup
  logic                     div_start;
  logic                     div_done;
  logic signed [DIVD_W-1:0] div_dividend;
  logic        [DIVS_W-1:0] div_divisor;
  logic signed [QUOT_W-1:0] div_quot;

  logic [SEG_W-1:0]        seg_eff;
  logic [SEG_W-1:0]        s_last;
  logic [SEG_W-1:0]        av;      // s - k
  logic                    can_load;
  logic                    at_last_k;
  logic signed [ACC_W-1:0] sum;
  logic signed [OUT_W-1:0] sat;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      segments <= SEGMENTS_RST;
      min_x    <= MIN_RST;
      max_x    <= MAX_RST;
      min_y    <= MIN_RST;
      max_y    <= MAX_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SEGMENTS: segments <= cfg_data[SEG_W-1:0];
        REG_MIN_X:    min_x    <= cfg_data;
        REG_MAX_X:    max_x    <= cfg_data;
        REG_MIN_Y:    min_y    <= cfg_data;
        REG_MAX_Y:    max_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- helpers
  always_comb begin
    // zero acts as one, anything above the bound is clamped
    if (segments == '0) begin
      seg_eff = SEG_W'(1);
    end else if (segments > SEG_W'(MAX_SEGMENTS)) begin
      seg_eff = SEG_W'(MAX_SEGMENTS);
    end else begin
      seg_eff = segments;
    end
    s_last    = s_reg - SEG_W'(1);
    av        = s_reg - k;
    at_last_k = (k == s_last);
    can_load  = !out_valid || !out_stall;
    // remap tail: add range low bound and saturate
    sum = acc + ACC_W'(axis ? min_y : min_x);
    if (sum > SAT_HI) begin
      sat = SAT_HI[OUT_W-1:0];
    end else if (sum < SAT_LO) begin
      sat = SAT_LO[OUT_W-1:0];
    end else begin
      sat = sum[OUT_W-1:0];
    end
    // round(num / d) as floor((2*num + d) / (2*d))
    div_dividend = DIVD_W'({acc[DIVD_W-2:0], 1'b0}) + DIVD_W'(d);
    div_divisor  = {d, 1'b0};
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_SS;
      ST_SS:       state_next = ST_SSS;
      ST_SSS:      state_next = ST_D;
      ST_D:        state_next = ST_AA;
      ST_AA:       state_next = ST_BB;
      ST_BB:       state_next = ST_W0;
      ST_W0:       state_next = ST_W1;
      ST_W1:       state_next = ST_W2;
      ST_W2:       state_next = ST_W3;
      ST_W3:       state_next = ST_M0;
      ST_M0:       state_next = ST_M1;
      ST_M1:       state_next = ST_M2;
      ST_M2:       state_next = ST_M3;
      ST_M3:       state_next = ST_ACC;
      ST_ACC:      state_next = ST_DIV;
      ST_DIV:      state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_next = ST_MAP;
      ST_MAP:      state_next = ST_RND;
      ST_RND:      state_next = ST_SAT;
      ST_SAT: begin
        if (axis) begin
          state_next = ST_EMIT;
        end else begin
          state_next = endpt ? ST_MAP : ST_M0;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          priority if (endpt) begin
            state_next = ST_IDLE;
          end else if (at_last_k) begin
            state_next = closing ? ST_MAP : ST_IDLE;
          end else begin
            state_next = ST_AA;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  // multiplier operand select; the product is registered into prod on the next cycle
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    in_stall  = (state != ST_IDLE);
    unique case (state)
      ST_SS: begin
        mul_a = MUL_A_W'(s_reg);
        mul_b = MUL_B_W'(s_reg);
      end
      ST_SSS: begin
        mul_a = MUL_A_W'(prod[SQ_W-1:0]);
        mul_b = MUL_B_W'(s_reg);
      end
      ST_AA: begin
        mul_a = MUL_A_W'(av);
        mul_b = MUL_B_W'(av);
      end
      ST_BB: begin
        mul_a = MUL_A_W'(k);
        mul_b = MUL_B_W'(k);
      end
      ST_W0: begin
        mul_a = MUL_A_W'(aa);
        mul_b = MUL_B_W'(av);
      end
      ST_W1: begin
        mul_a = MUL_A_W'(aa);
        mul_b = MUL_B_W'(k) * MUL_B_W'(BINOM_MID);
      end
      ST_W2: begin
        mul_a = MUL_A_W'(bb);
        mul_b = MUL_B_W'(av) * MUL_B_W'(BINOM_MID);
      end
      ST_W3: begin
        mul_a = MUL_A_W'(bb);
        mul_b = MUL_B_W'(k);
      end
      ST_M0: begin
        mul_a = MUL_A_W'(w0);
        mul_b = MUL_B_W'(axis ? hy[0] : hx[0]);
      end
      ST_M1: begin
        mul_a = MUL_A_W'(w1);
        mul_b = MUL_B_W'(axis ? hy[1] : hx[1]);
      end
      ST_M2: begin
        mul_a = MUL_A_W'(w2);
        mul_b = MUL_B_W'(axis ? hy[2] : hx[2]);
      end
      ST_M3: begin
        mul_a = MUL_A_W'(w3);
        mul_b = MUL_B_W'(axis ? hy[3] : hx[3]);
      end
      ST_DIV: div_start = 1'b1;
      ST_MAP: begin
        mul_a = axis ? span_y : span_x;
        mul_b = MUL_B_W'(p);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      axis      <= 1'b0;
      endpt     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT && can_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          k     <= '0;
          axis  <= 1'b0;
          endpt <= 1'b0;
        end
        ST_SAT: if (!axis) axis <= 1'b1;
        ST_EMIT: begin
          if (can_load) begin
            axis <= 1'b0;
            if (!endpt && at_last_k && closing) begin
              endpt <= 1'b1;
            end else if (!endpt && !at_last_k) begin
              k <= k + SEG_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          hx[0]   <= start_x;
          hy[0]   <= start_y;
          hx[1]   <= handle_a_x;
          hy[1]   <= handle_a_y;
          hx[2]   <= handle_b_x;
          hy[2]   <= handle_b_y;
          hx[3]   <= end_x;
          hy[3]   <= end_y;
          closing <= closing_segment;
          s_reg   <= seg_eff;
          span_x  <= SPAN_W'(max_x) - SPAN_W'(min_x);
          span_y  <= SPAN_W'(max_y) - SPAN_W'(min_y);
        end
      end
      ST_D:   d  <= prod[CUBE_W-1:0];
      ST_BB:  aa <= prod[SQ_W-1:0];
      ST_W0:  bb <= prod[SQ_W-1:0];
      ST_W1:  w0 <= prod[WT_W-1:0];
      ST_W2:  w1 <= prod[WT_W-1:0];
      ST_W3:  w2 <= prod[WT_W-1:0];
      // on the y pass prod no longer holds the w3 product, keep the weight
      ST_M0:  if (!axis) w3 <= prod[WT_W-1:0];
      ST_M1:  acc <= prod;
      ST_M2:  acc <= acc + prod;
      ST_M3:  acc <= acc + prod;
      ST_ACC: acc <= acc + prod;
      ST_DIV_WAIT: if (div_done) p <= div_quot;
      ST_RND: acc <= (prod + HALF) >>> COORD_FRAC_BITS;
      ST_SAT: begin
        if (!axis) begin
          res_x <= sat;
          if (endpt) p <= hy[3];
        end else begin
          res_y <= sat;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          point_x    <= res_x;
          point_y    <= res_y;
          last_point <= endpt || (at_last_k && !closing);
          if (!endpt && at_last_k && closing) p <= hx[3];
        end
      end
      default: ;
    endcase
  end

  cbt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

`ifndef ASSERT_OFF
  // an accepted segment always starts the cube setup
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == ST_SS)
    else $error("accepted segment did not start setup");

  // point index never runs past the segment count
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> k < s_reg)
    else $error("point index out of range");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV_WAIT)
    else $error("divider done outside wait state");

  // end point is only produced for a closing segment
  a_endpt_closing: assert property (@(posedge clk) disable iff (rst)
    endpt |-> closing)
    else $error("end point on a non-closing segment");

  // the end point beat finishes the segment
  a_endpt_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && can_load && endpt |=> state == ST_IDLE && last_point)
    else $error("end point beat did not close the segment");
`endif

endmodule
